### hdl/rha_pkg.sv
// rha_pkg: shared types, constants and helpers for the row harmonic analyzer.
// Used by every module of the block and by the port payloads; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rha_pkg;

  // sample limits (defaults for the top level parameters)
  localparam int unsigned RHA_MIN_SAMPLES = 400;
  localparam int unsigned RHA_MAX_SAMPLES = 65536;

  // configuration reset values
  localparam logic [31:0] PHASE_STEP_RST  = 32'd1048576;
  localparam logic [7:0]  STRIDE_RST      = 8'd1;
  localparam logic [31:0] INV_SCALE_RST   = 32'd65536;

  // harmonic numbers
  localparam logic [31:0] HARM_LO = 32'd21;
  localparam logic [31:0] HARM_HI = 32'd142;

  // CORDIC: Q2.30 trig values carried in 34 bits
  localparam int TRIG_W = 34;
  localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 34'sd652032874;

  // output limits
  localparam logic [63:0] CAP48    = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [31:0] USED_MAX = 32'd131071;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_PHASE_STEP    = 2'd0,
    REG_SAMPLE_STRIDE = 2'd1,
    REG_REVERSE_DIR   = 2'd2,
    REG_INVERSE_SCALE = 2'd3
  } rha_reg_idx_t;

  // operations of the divide / square-root unit
  typedef enum logic {
    DS_DIV  = 1'b0,
    DS_SQRT = 1'b1
  } rha_ds_op_t;

  // input item
  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] ring_latitude;
    logic               last_point;
  } rha_in_t;

  // result item
  typedef struct packed {
    logic signed [31:0] out_latitude;
    logic signed [31:0] mean_radial;
    logic signed [31:0] mean_tangential;
    logic signed [31:0] mean_axial;
    logic [31:0]        rms_deviation;
    logic [31:0]        amp_mode_21;
    logic [31:0]        amp_mode_142;
    logic [16:0]        used_samples;
    logic               too_few;
  } rha_out_t;

  // CORDIC control and status
  typedef struct packed {
    logic        start;
    logic [31:0] angle;
  } rha_cordic_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [TRIG_W-1:0] cos_val;
    logic signed [TRIG_W-1:0] sin_val;
  } rha_cordic_rsp_t;

  // divide / square-root control and status
  typedef struct packed {
    logic        start;
    rha_ds_op_t  op;
    logic        sgn;
    logic [63:0] arg;
    logic [31:0] divisor;
  } rha_ds_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } rha_ds_rsp_t;

  // arctangent table in turns, Q2.32: 2^32 per turn scaled to 2^31 per half turn
  function automatic logic signed [TRIG_W-1:0] atan_lookup(input logic [3:0] i);
    logic signed [TRIG_W-1:0] v;
    case (i)
      4'd0:    v = 34'sd536870912;
      4'd1:    v = 34'sd316933406;
      4'd2:    v = 34'sd167458907;
      4'd3:    v = 34'sd85004756;
      4'd4:    v = 34'sd42667331;
      4'd5:    v = 34'sd21354465;
      4'd6:    v = 34'sd10679838;
      4'd7:    v = 34'sd5340245;
      4'd8:    v = 34'sd2670163;
      4'd9:    v = 34'sd1335087;
      4'd10:   v = 34'sd667544;
      4'd11:   v = 34'sd333772;
      4'd12:   v = 34'sd166886;
      4'd13:   v = 34'sd83443;
      4'd14:   v = 34'sd41721;
      default: v = 34'sd20861;
    endcase
    return v;
  endfunction

  // clamp to the int32 range
  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -72'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/rha_stream_if.sv
// rha_stream_if: valid/ready channel carrying one payload struct per item.
// Payload type is a parameter; used with rha_pkg item types.
`timescale 1ns / 1ps
`default_nettype none

interface rha_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/rha_cordic.sv
// rha_cordic: iterative 16-step CORDIC rotator giving cos and sin in Q2.30.
// One shift-add step per cycle; depends on rha_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rha_cordic import rha_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  rha_cordic_req_t req,
  output rha_cordic_rsp_t rsp
);

  logic signed [TRIG_W-1:0] x_r, y_r, z_r;
  logic signed [TRIG_W-1:0] dx, dy, at;
  logic [3:0]  it_r;
  logic        busy_r, done_r, neg_r;
  logic        fold;
  logic [31:0] ang_f;

  // fold the angle into [-90, 90) degrees
  assign fold  = (req.angle[31:30] == 2'b01) || (req.angle[31:30] == 2'b10);
  assign ang_f = fold ? (req.angle + 32'h8000_0000) : req.angle;

  assign dx = y_r >>> it_r;
  assign dy = x_r >>> it_r;
  assign at = atan_lookup(it_r);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        it_r   <= '0;
      end else if (busy_r) begin
        it_r <= it_r + 4'd1;
        if (it_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // rotation datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r   <= CORDIC_X0;
      y_r   <= '0;
      z_r   <= TRIG_W'(signed'(ang_f));
      neg_r <= fold;
    end else if (busy_r) begin
      if (!z_r[TRIG_W-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
    end
  end

  assign rsp.done    = done_r;
  assign rsp.cos_val = neg_r ? -x_r : x_r;
  assign rsp.sin_val = neg_r ? -y_r : y_r;

endmodule

`default_nettype wire

### hdl/rha_divsqrt.sv
// rha_divsqrt: shared bit-serial unit, 64-by-DIV_W floor division (one quotient
// bit per cycle) or 64-bit integer square root (one root bit per cycle). Uses rha_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rha_divsqrt import rha_pkg::*; #(
  parameter int DIV_W = 17
) (
  input  logic        clk,
  input  logic        rst_n,
  input  rha_ds_req_t req,
  output rha_ds_rsp_t rsp
);

  logic             busy_r, done_r, neg_r;
  rha_ds_op_t       op_r;
  logic [5:0]       cnt_r;
  logic [63:0]      w_r, r_r, b_r;
  logic [DIV_W-1:0] rem_r, d_r;
  logic [DIV_W:0]   rem_sh;
  logic             ge;
  logic [64:0]      rb;
  logic             sq_ge;

  // division step: shift in the next dividend bit
  assign rem_sh = {rem_r, w_r[63]};
  assign ge     = rem_sh >= {1'b0, d_r};
  // root step: try r + b
  assign rb     = {1'b0, r_r} + {1'b0, b_r};
  assign sq_ge  = {1'b0, w_r} >= rb;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= (req.op == DS_DIV) ? 6'd63 : 6'd31;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r  <= req.op;
      neg_r <= req.sgn && req.arg[63] && (req.op == DS_DIV);
      w_r   <= (req.sgn && req.arg[63] && (req.op == DS_DIV)) ? ~req.arg : req.arg;
      rem_r <= '0;
      d_r   <= req.divisor[DIV_W-1:0];
      r_r   <= '0;
      b_r   <= 64'h4000_0000_0000_0000;
    end else if (busy_r) begin
      unique case (op_r)
        DS_DIV: begin
          rem_r <= ge ? DIV_W'(rem_sh - {1'b0, d_r}) : rem_sh[DIV_W-1:0];
          w_r   <= {w_r[62:0], ge};
        end
        DS_SQRT: begin
          if (sq_ge) begin
            w_r <= w_r - rb[63:0];
            r_r <= (r_r >> 1) + b_r;
          end else begin
            r_r <= r_r >> 1;
          end
          b_r <= b_r >> 2;
        end
        default: ;
      endcase
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = (op_r == DS_SQRT) ? r_r : (neg_r ? ~w_r : w_r);

endmodule

`default_nettype wire

### hdl/row_harmonic_analyzer_top.sv
// Row harmonic analyzer. Takes one ring of 3-D points (signed Q16.16), one point
// per item on in_ch, the last one flagged by last_point. Every sample_stride-th
// point is scaled by inverse_scale, rotated into the local frame by its longitude
// angle (32-bit phase accumulator stepped by phase_step), and accumulated into the
// mean, square and harmonic 21 / 142 sums. On the last point one result item goes
// out on out_ch with means, RMS, both mode amplitudes, sample count and too_few.
// Configuration: cfg_wr_en / cfg_index / cfg_data, to be written by the user only
// while the block is idle; the block itself does not enforce this. A sampled point
// takes three passes through the single 16-step CORDIC rotator and 22 products on
// the one shared 35x35 multiplier. A non-empty ring's last point adds 16
// divisions by the sample count on the radix-2 divider and three 32-step
// square roots on the same unit. in_ch.ready is high only while no point is in
// work. A finished result waits in the output register; the next ring's points
// are taken meanwhile, and only a second result waits for out_ch.ready.
// Reset (synchronous, active low) restores the register defaults, clears the
// ring sums and drops any pending result. Depends on rha_pkg, rha_stream_if,
// rha_cordic and rha_divsqrt.
`timescale 1ns / 1ps
`default_nettype none

module row_harmonic_analyzer_top import rha_pkg::*; #(
  parameter int unsigned MIN_SAMPLES = RHA_MIN_SAMPLES,
  parameter int unsigned MAX_SAMPLES = RHA_MAX_SAMPLES
) (
  input  logic        clk,
  input  logic        rst_n,
  rha_stream_if.sink   in_ch,
  rha_stream_if.source out_ch,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_SCALE  = 13'b0000000000010,
    ST_TRIGGO = 13'b0000000000100,
    ST_TRIGW  = 13'b0000000001000,
    ST_ROT    = 13'b0000000010000,
    ST_SQ     = 13'b0000000100000,
    ST_HARM   = 13'b0000001000000,
    ST_DIVGO  = 13'b0000010000000,
    ST_DIVW   = 13'b0000100000000,
    ST_FMUL   = 13'b0001000000000,
    ST_SQRTGO = 13'b0010000000000,
    ST_SQRTW  = 13'b0100000000000,
    ST_EMIT   = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [31:0] phase_step_r, inv_scale_r;
  logic [7:0]  stride_r;
  logic        reverse_r;

  // ring state
  logic [31:0]        phase_acc_r;
  logic [7:0]         stride_cnt_r;
  logic [CNT_W-1:0]   cnt_r;
  logic signed [63:0] vsum_r [3];
  logic [63:0]        sq_sum_r;
  logic signed [63:0] hsum_r [12];

  // current item
  logic signed [31:0] x_raw_r, y_raw_r, z_raw_r, lat_r;
  logic               last_r;
  logic [31:0]        ang_r;
  logic signed [31:0] px_r, py_r, pz_r;
  logic signed [31:0] loc_r [3];

  // sequencer and shared multiplier
  logic [2:0]         step_r;
  logic [1:0]         pass_r;
  logic [3:0]         fidx_r;
  logic signed [34:0] mul_a, mul_b;
  logic signed [69:0] prod_r;
  logic signed [71:0] acc_r;

  // final results
  logic [63:0]        q_r, tmp_r, msq_r, norm_r;
  logic signed [31:0] mean_r [3];
  logic [31:0]        rms_r, a21_r, a142_r;

  // output register
  logic     out_valid_r;
  rha_out_t out_data_r, out_nxt;

  // sub-unit control
  rha_cordic_req_t cordic_req;
  rha_cordic_rsp_t cordic_rsp;
  rha_ds_req_t     ds_req;
  rha_ds_rsp_t     ds_rsp;

  // handshakes and item bookkeeping
  logic        acc_in, take_sample, emit_go, fmul_end;
  logic [7:0]  stride_eff;
  logic [8:0]  stride_inc;
  logic [1:0]  lidx;
  logic [3:0]  hidx;
  logic signed [31:0] lsel, mq;
  logic signed [71:0] prod_x, harm_t;
  logic [63:0] m_mag, var_v, var_c, norm_c, lo_sq;
  logic [64:0] sq_add, dbl;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign acc_in       = in_ch.valid && in_ch.ready;
  assign take_sample  = (stride_cnt_r == 8'd0) && (cnt_r < CNT_MAX);
  assign stride_eff   = (stride_r == 8'd0) ? 8'd1 : stride_r;
  assign stride_inc   = {1'b0, stride_cnt_r} + 9'd1;
  assign emit_go      = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);

  assign prod_x = 72'(prod_r);
  assign harm_t = prod_x >>> 30;
  assign mq     = sat32(72'(signed'(q_r)));
  assign m_mag  = q_r[63] ? (64'd0 - q_r) : q_r;
  assign lo_sq  = tmp_r + {prod_r[30:0], 33'd0};
  assign sq_add = {1'b0, sq_sum_r} + {1'b0, 16'd0, prod_r[63:16]};
  assign var_v  = (q_r > msq_r) ? (q_r - msq_r) : 64'd0;
  assign var_c  = (var_v > CAP48) ? CAP48 : var_v;
  assign norm_c = (norm_r > CAP48) ? CAP48 : norm_r;
  assign dbl    = {ds_rsp.result, 1'b0};
  assign hidx   = ((pass_r == 2'd1) ? 4'd0 : 4'd6) + 4'(step_r - 3'd1);

  // step that ends the current final-multiply sequence
  assign fmul_end = ((fidx_r < 4'd3) && (step_r == 3'd1)) ||
                    ((fidx_r == 4'd3) && (step_r == 3'd0)) ||
                    ((fidx_r > 4'd3) && (step_r == 3'd2));

  // local component feeding the multiplier
  always_comb begin
    lidx = 2'd0;
    if (state_r == ST_SQ) lidx = step_r[1:0];
    else if (step_r < 3'd3) lidx = step_r[1:0];
    else lidx = 2'(step_r - 3'd3);
    if (lidx == 2'd3) lidx = 2'd0;
  end
  assign lsel = loc_r[lidx];

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_SCALE: begin
        mul_b = {3'b000, inv_scale_r};
        case (step_r)
          3'd0:    mul_a = 35'(x_raw_r);
          3'd1:    mul_a = 35'(y_raw_r);
          default: mul_a = 35'(z_raw_r);
        endcase
      end
      ST_ROT: begin
        case (step_r)
          3'd0: begin mul_a = 35'(px_r); mul_b = 35'(cordic_rsp.cos_val); end
          3'd1: begin mul_a = 35'(py_r); mul_b = 35'(cordic_rsp.sin_val); end
          3'd2: begin mul_a = 35'(py_r); mul_b = 35'(cordic_rsp.cos_val); end
          default: begin mul_a = 35'(px_r); mul_b = 35'(cordic_rsp.sin_val); end
        endcase
      end
      ST_SQ: begin
        mul_a = 35'(lsel);
        mul_b = 35'(lsel);
      end
      ST_HARM: begin
        mul_a = 35'(lsel);
        mul_b = (step_r < 3'd3) ? 35'(cordic_rsp.cos_val) : 35'(cordic_rsp.sin_val);
      end
      ST_FMUL: begin
        if (fidx_r < 4'd3) begin
          mul_a = 35'(mq);
          mul_b = 35'(mq);
        end else begin
          mul_a = {3'b000, m_mag[31:0]};
          mul_b = (step_r == 3'd0) ? {3'b000, m_mag[31:0]} : {3'b000, m_mag[63:32]};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) prod_r <= mul_a * mul_b;

  // CORDIC request: local frame angle, then the two harmonic angles
  always_comb begin
    cordic_req.start = (state_r == ST_TRIGGO);
    unique case (pass_r)
      2'd0:    cordic_req.angle = ang_r;
      2'd1:    cordic_req.angle = 32'(ang_r * HARM_LO);
      default: cordic_req.angle = 32'(ang_r * HARM_HI);
    endcase
  end

  // divide / root request
  always_comb begin
    ds_req.start   = (state_r == ST_DIVGO) || (state_r == ST_SQRTGO);
    ds_req.op      = (state_r == ST_SQRTGO) ? DS_SQRT : DS_DIV;
    ds_req.sgn     = (fidx_r != 4'd3);
    ds_req.divisor = 32'(cnt_r);
    if (state_r == ST_SQRTGO)
      ds_req.arg = (fidx_r == 4'd3) ? {var_c[47:0], 16'd0} : {norm_c[47:0], 16'd0};
    else if (fidx_r < 4'd3)
      ds_req.arg = vsum_r[fidx_r[1:0]];
    else if (fidx_r == 4'd3)
      ds_req.arg = sq_sum_r;
    else
      ds_req.arg = hsum_r[fidx_r - 4'd4];
  end

  rha_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cordic_req),
    .rsp   (cordic_rsp)
  );

  rha_divsqrt #(.DIV_W(CNT_W)) u_divsqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ds_req),
    .rsp   (ds_rsp)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc_in) begin
          if (take_sample) state_nxt = ST_SCALE;
          else if (in_ch.data.last_point)
            state_nxt = (cnt_r == '0) ? ST_EMIT : ST_DIVGO;
        end
      end
      ST_SCALE:  if (step_r == 3'd3) state_nxt = ST_TRIGGO;
      ST_TRIGGO: state_nxt = ST_TRIGW;
      ST_TRIGW:  if (cordic_rsp.done) state_nxt = (pass_r == 2'd0) ? ST_ROT : ST_HARM;
      ST_ROT:    if (step_r == 3'd4) state_nxt = ST_SQ;
      ST_SQ:     if (step_r == 3'd3) state_nxt = ST_TRIGGO;
      ST_HARM: begin
        if (step_r == 3'd6) begin
          if (pass_r == 2'd1) state_nxt = ST_TRIGGO;
          else state_nxt = last_r ? ST_DIVGO : ST_IDLE;
        end
      end
      ST_DIVGO:  state_nxt = ST_DIVW;
      ST_DIVW:   if (ds_rsp.done) state_nxt = ST_FMUL;
      ST_FMUL: begin
        if (fmul_end)
          state_nxt = ((fidx_r == 4'd3) || (fidx_r == 4'd9) || (fidx_r == 4'd15)) ?
                      ST_SQRTGO : ST_DIVGO;
      end
      ST_SQRTGO: state_nxt = ST_SQRTW;
      ST_SQRTW:  if (ds_rsp.done) state_nxt = (fidx_r == 4'd15) ? ST_EMIT : ST_DIVGO;
      ST_EMIT:   if (emit_go) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= PHASE_STEP_RST;
      stride_r     <= STRIDE_RST;
      reverse_r    <= 1'b0;
      inv_scale_r  <= INV_SCALE_RST;
    end else if (cfg_wr_en) begin
      unique case (rha_reg_idx_t'(cfg_index))
        REG_PHASE_STEP:    phase_step_r <= cfg_data;
        REG_SAMPLE_STRIDE: stride_r     <= cfg_data[7:0];
        REG_REVERSE_DIR:   reverse_r    <= cfg_data[0];
        REG_INVERSE_SCALE: inv_scale_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ring state: counters and sums
  always_ff @(posedge clk) begin
    if (!rst_n || emit_go) begin
      phase_acc_r  <= '0;
      stride_cnt_r <= '0;
      cnt_r        <= '0;
      sq_sum_r     <= '0;
      msq_r        <= '0;
      norm_r       <= '0;
      for (int k = 0; k < 3; k++) vsum_r[k] <= '0;
      for (int k = 0; k < 12; k++) hsum_r[k] <= '0;
    end else begin
      if (acc_in) begin
        phase_acc_r  <= phase_acc_r + phase_step_r;
        stride_cnt_r <= (stride_inc >= {1'b0, stride_eff}) ? 8'd0 : stride_inc[7:0];
        if (take_sample) cnt_r <= cnt_r + 1'b1;
      end
      // local vector and its squared norm
      if (state_r == ST_SQ) begin
        if (step_r == 3'd0) begin
          for (int k = 0; k < 3; k++) vsum_r[k] <= vsum_r[k] + 64'(loc_r[k]);
        end else begin
          sq_sum_r <= sq_add[64] ? '1 : sq_add[63:0];
        end
      end
      // harmonic products
      if ((state_r == ST_HARM) && (step_r != 3'd0))
        hsum_r[hidx] <= hsum_r[hidx] + harm_t[63:0];
      // squared norms of the means and of each harmonic group
      if (state_r == ST_FMUL) begin
        if ((fidx_r < 4'd3) && (step_r == 3'd1))
          msq_r <= msq_r + {16'd0, prod_r[63:16]};
        if ((fidx_r > 4'd3) && (step_r == 3'd2))
          norm_r <= norm_r + {16'd0, lo_sq[63:16]};
      end
      if ((state_r == ST_SQRTW) && ds_rsp.done && (fidx_r == 4'd9)) norm_r <= '0;
    end
  end

  // sequencer counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      pass_r <= '0;
      fidx_r <= '0;
    end else begin
      if (state_nxt != state_r) step_r <= '0;
      else step_r <= step_r + 3'd1;
      if (state_r == ST_IDLE) begin
        pass_r <= 2'd0;
        fidx_r <= 4'd0;
      end
      if ((state_r == ST_SQ) && (step_r == 3'd3)) pass_r <= 2'd1;
      if ((state_r == ST_HARM) && (step_r == 3'd6) && (pass_r == 2'd1)) pass_r <= 2'd2;
      if ((state_r == ST_FMUL) && fmul_end && (state_nxt == ST_DIVGO))
        fidx_r <= fidx_r + 4'd1;
      if ((state_r == ST_SQRTW) && ds_rsp.done) fidx_r <= fidx_r + 4'd1;
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (acc_in) begin
      x_raw_r <= in_ch.data.point_x;
      y_raw_r <= in_ch.data.point_y;
      z_raw_r <= in_ch.data.point_z;
      lat_r   <= in_ch.data.ring_latitude;
      last_r  <= in_ch.data.last_point;
      ang_r   <= reverse_r ? (32'd0 - phase_acc_r) : phase_acc_r;
    end
    // scaled coordinates
    if (state_r == ST_SCALE) begin
      case (step_r)
        3'd1:    px_r <= sat32(prod_x >>> 16);
        3'd2:    py_r <= sat32(prod_x >>> 16);
        3'd3:    pz_r <= sat32(prod_x >>> 16);
        default: ;
      endcase
    end
    // rotation into the local frame
    if (state_r == ST_ROT) begin
      case (step_r)
        3'd1, 3'd3: acc_r <= prod_x;
        3'd2:       loc_r[0] <= sat32((acc_r + prod_x) >>> 30);
        3'd4: begin
          loc_r[1] <= sat32((acc_r - prod_x) >>> 30);
          loc_r[2] <= pz_r;
        end
        default: ;
      endcase
    end
    // final statistics
    if ((state_r == ST_DIVW) && ds_rsp.done) q_r <= ds_rsp.result;
    if ((state_r == ST_FMUL) && (step_r == 3'd0) && (fidx_r < 4'd3))
      mean_r[fidx_r[1:0]] <= mq;
    if ((state_r == ST_FMUL) && (step_r == 3'd1)) tmp_r <= prod_r[63:0];
    if ((state_r == ST_SQRTW) && ds_rsp.done) begin
      case (fidx_r)
        4'd3:    rms_r  <= (ds_rsp.result > 64'hFFFF_FFFF) ? '1 : ds_rsp.result[31:0];
        4'd9:    a21_r  <= (dbl > 65'hFFFF_FFFF) ? '1 : dbl[31:0];
        default: a142_r <= (dbl > 65'hFFFF_FFFF) ? '1 : dbl[31:0];
      endcase
    end
  end

  // result assembly; an empty ring reports zero means, RMS and amplitudes
  always_comb begin
    out_nxt                 = '0;
    out_nxt.out_latitude    = lat_r;
    out_nxt.used_samples    = (32'(cnt_r) > USED_MAX) ? 17'(USED_MAX) : 17'(cnt_r);
    out_nxt.too_few         = (32'(cnt_r) < 32'(MIN_SAMPLES));
    if (cnt_r != '0) begin
      out_nxt.mean_radial     = mean_r[0];
      out_nxt.mean_tangential = mean_r[1];
      out_nxt.mean_axial      = mean_r[2];
      out_nxt.rms_deviation   = rms_r;
      out_nxt.amp_mode_21     = a21_r;
      out_nxt.amp_mode_142    = a142_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) out_data_r <= out_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // checks
  a_cordic_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cordic_rsp.done |-> state_r == ST_TRIGW)
    else $error("rotator finished outside its wait state");

  a_ds_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    ds_rsp.done |-> (state_r == ST_DIVW || state_r == ST_SQRTW))
    else $error("divide/root unit finished outside its wait state");

  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("sample count beyond limit");

  a_ring_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |=> (cnt_r == '0 && phase_acc_r == '0 && stride_cnt_r == '0 && out_valid_r))
    else $error("ring state not cleared after result");

endmodule

`default_nettype wire
